// ===== design/iss_pkg.sv =====
// Shared types and constants for the indexed sequence store.
package iss_pkg;

  // Fixed field widths
  localparam int POS_W      = 9;
  localparam int WORD_W     = 32;
  localparam int CNT_OUT_W  = 9;

  // Default number of stored words
  localparam int CAPACITY_DEF = 256;

  typedef enum logic [1:0] {
    OP_GET    = 2'd0,
    OP_SET    = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

endpackage

// ===== design/indexed_sequence_store.sv =====
// Ordered word store with get, set, insert and delete, shifting one word per cycle.
//
//  channel | direction | signals                                   | transfer
//  --------+-----------+-------------------------------------------+------------------
//  in_     | input     | in_opcode, in_position, in_value          | in_valid & in_ready
//  out_    | output    | out_read_value, out_count, out_status     | out_valid & out_ready
//
// A get passes through the idle, check, read-wait and response states; set and flagged
// operations skip the read wait; insert and delete run a shift loop between check and response.
// The shift loop moves one word per cycle through the word memory's one read and one write port.
// Reset clears the state, count, shift flag and output valid; the word memory and data registers are not cleared.
// in_ready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next item may be taken meanwhile.
module indexed_sequence_store #(
  parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_opcode,
  input  logic [iss_pkg::POS_W-1:0]          in_position,
  input  logic signed [iss_pkg::WORD_W-1:0]  in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [iss_pkg::WORD_W-1:0]  out_read_value,
  output logic [iss_pkg::CNT_OUT_W-1:0]      out_count,
  output logic [1:0]                         out_status
);
  import iss_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int W  = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GETW,
    S_INS,
    S_DEL,
    S_RESP
  } state_t;

  state_t                     state_r, state_nxt;
  opcode_t                    op_r, op_nxt;
  logic [POS_W-1:0]           pos_r, pos_nxt;
  logic signed [WORD_W-1:0]   val_r, val_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic [AW-1:0]              wa_r, wa_nxt;
  logic                       pend_r, pend_nxt;
  logic signed [WORD_W-1:0]   res_val_r, res_val_nxt;
  status_t                    res_st_r, res_st_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [WORD_W-1:0]   out_val_r, out_val_nxt;
  logic [CNT_OUT_W-1:0]       out_count_r, out_count_nxt;
  status_t                    out_st_r, out_st_nxt;

  // Word memory ports
  logic signed [WORD_W-1:0]   mem [CAPACITY];
  logic signed [WORD_W-1:0]   rd_data_r;
  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic signed [WORD_W-1:0]   mem_wd;
  logic                       mem_re;
  logic [AW-1:0]              mem_ra;

  logic [W-1:0]               pos_w;
  logic [W-1:0]               cnt_w;
  logic [W-1:0]               idx_w;

  assign pos_w = W'(pos_r);
  assign cnt_w = W'(count_r);
  assign idx_w = W'(idx_r);

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_read_value = out_val_r;
  assign out_count      = out_count_r;
  assign out_status     = out_st_r;

  // Sequencer and next-state logic
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    pos_nxt       = pos_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    wa_nxt        = wa_r;
    pend_nxt      = pend_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_val_nxt   = out_val_r;
    out_count_nxt = out_count_r;
    out_st_nxt    = out_st_r;
    mem_we        = 1'b0;
    mem_wa        = wa_r;
    mem_wd        = rd_data_r;
    mem_re        = 1'b0;
    mem_ra        = AW'(pos_r);

    unique case (state_r)
      S_IDLE: begin
        // Capture the operation on transfer
        if (in_valid) begin
          op_nxt    = opcode_t'(in_opcode);
          pos_nxt   = in_position;
          val_nxt   = in_value;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        // Check the operation and start it
        res_val_nxt = '0;
        res_st_nxt  = ST_OK;
        state_nxt   = S_RESP;
        if (op_r == OP_INSERT) begin
          if (cnt_w == W'(CAPACITY)) begin
            res_st_nxt = ST_FULL;
          end else if (pos_w > cnt_w) begin
            res_st_nxt = ST_RANGE;
          end else begin
            idx_nxt   = count_r;
            pend_nxt  = 1'b0;
            state_nxt = S_INS;
          end
        end else if (count_r == '0) begin
          res_st_nxt = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          res_st_nxt = ST_RANGE;
        end else begin
          unique case (op_r)
            OP_GET: begin
              mem_re    = 1'b1;
              mem_ra    = AW'(pos_r);
              state_nxt = S_GETW;
            end
            OP_SET: begin
              mem_we = 1'b1;
              mem_wa = AW'(pos_r);
              mem_wd = val_r;
            end
            OP_DELETE: begin
              idx_nxt   = CW'(pos_r);
              pend_nxt  = 1'b0;
              state_nxt = S_DEL;
            end
            default: begin
              res_st_nxt = ST_OK;
            end
          endcase
        end
      end

      S_GETW: begin
        // Take the registered read word
        res_val_nxt = rd_data_r;
        state_nxt   = S_RESP;
      end

      S_INS: begin
        // Move words up one place, top first, then drop the new word in
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = wa_r;
          mem_wd = rd_data_r;
        end
        if (idx_w > pos_w) begin
          mem_re   = 1'b1;
          mem_ra   = AW'(idx_r - 1'b1);
          wa_nxt   = AW'(idx_r);
          idx_nxt  = idx_r - 1'b1;
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          mem_we    = 1'b1;
          mem_wa    = AW'(pos_r);
          mem_wd    = val_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_DEL: begin
        // Move words down one place, bottom first
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = wa_r;
          mem_wd = rd_data_r;
        end
        if ((idx_r + 1'b1) < count_r) begin
          mem_re   = 1'b1;
          mem_ra   = AW'(idx_r + 1'b1);
          wa_nxt   = AW'(idx_r);
          idx_nxt  = idx_r + 1'b1;
          pend_nxt = 1'b1;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RESP;
        end
      end

      S_RESP: begin
        // Load the output register once it is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_val_r;
          out_count_nxt = CNT_OUT_W'(count_r);
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r        <= op_nxt;
    pos_r       <= pos_nxt;
    val_r       <= val_nxt;
    idx_r       <= idx_nxt;
    wa_r        <= wa_nxt;
    res_val_r   <= res_val_nxt;
    res_st_r    <= res_st_nxt;
    out_val_r   <= out_val_nxt;
    out_count_r <= out_count_nxt;
    out_st_r    <= out_st_nxt;
  end

  // Word memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count exceeds capacity");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_FULL) |-> out_count_r == CNT_OUT_W'(CAPACITY))
    else $error("full status with store not full");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_EMPTY) |-> out_count_r == '0)
    else $error("empty status with words stored");

  a_start_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) |-> $past(state_r == S_IDLE && in_valid))
    else $error("operation started without input transfer");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_RESP))
    else $error("result shown outside response step");

endmodule
